// ===== rtl/tasps_pkg.sv =====
// ---------------------------------------------------------------------------
// Two-axis stepper pattern sequencer package
// Shared types, constants and the coil phase table.
// ---------------------------------------------------------------------------
package tasps_pkg;

    localparam int SizeLimit = 40;

    localparam int KindWidth   = 2;
    localparam int SampleWidth = 8;
    localparam int CoilWidth   = 4;
    localparam int SizeWidth   = 6;
    localparam int HoldWidth   = 9;

    typedef enum logic [KindWidth-1:0] {
        KIND_TICK   = 2'd0,
        KIND_TOGGLE = 2'd1,
        KIND_SPEED  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MOVE_X_FWD  = 2'd0,
        MOVE_Y_FWD  = 2'd1,
        MOVE_X_BACK = 2'd2,
        MOVE_Y_BACK = 2'd3
    } move_t;

    // Result item; the first member ends up in the highest bits.
    typedef struct packed {
        logic [SizeWidth-1:0] square_size;
        logic                 busy_flag;
        logic                 run_flag;
        logic [CoilWidth-1:0] y_coils;
        logic [CoilWidth-1:0] x_coils;
    } result_t;

    localparam int ResultWidth = $bits(result_t);

    function automatic logic [CoilWidth-1:0] phase_code(input logic [1:0] idx);
        logic [CoilWidth-1:0] code;
        case (idx)
            2'd0:    code = 4'd6;
            2'd1:    code = 4'd5;
            2'd2:    code = 4'd9;
            2'd3:    code = 4'd10;
            default: code = 4'd6;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/tasps_step_unit.sv =====
// ---------------------------------------------------------------------------
// Two-axis stepper pattern sequencer step unit
// Holds the sequencer state and computes its next value for one item.
// ---------------------------------------------------------------------------
module tasps_step_unit
    import tasps_pkg::*;
#(
    parameter int SIZE_LIMIT = SizeLimit
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [KindWidth-1:0]   kind,
    input  logic [SampleWidth-1:0] speed_sample,
    output result_t                status_next
);

    logic                 run_reg,   run_next;
    logic                 seq_reg,   seq_next;
    logic [SizeWidth-1:0] size_reg,  size_next;
    move_t                move_reg,  move_next;
    logic [SizeWidth-1:0] step_reg,  step_next;
    logic [1:0]           phase_reg, phase_next;
    logic [HoldWidth-1:0] left_reg,  left_next;
    logic [HoldWidth-1:0] hold_reg,  hold_next;
    logic [CoilWidth-1:0] x_reg,     x_next;
    logic [CoilWidth-1:0] y_reg,     y_next;

    logic [HoldWidth-1:0] left_dec;
    logic [HoldWidth-1:0] hold_load;
    logic [SizeWidth:0]   step_inc;
    logic [SizeWidth:0]   size_inc;
    logic [1:0]           adv_phase;
    logic [SizeWidth-1:0] adv_step;
    move_t                adv_move;
    logic [SizeWidth-1:0] adv_size;
    logic [1:0]           wr_phase;
    move_t                wr_move;
    logic                 do_write;
    logic [CoilWidth-1:0] wr_code;

    assign left_dec  = (left_reg != '0) ? left_reg - 1'b1 : '0;
    assign hold_load = (hold_reg == '0) ? HoldWidth'(1) : hold_reg;
    assign step_inc  = {1'b0, step_reg} + 1'b1;
    assign size_inc  = {1'b0, size_reg} + (SizeWidth+1)'(2);

    always_comb
    begin
        adv_phase = phase_reg + 1'b1;
        adv_step  = step_reg;
        adv_move  = move_reg;
        adv_size  = size_reg;
        if (phase_reg == 2'd3)
        begin
            if (step_inc <= {1'b0, size_reg})
            begin
                adv_step = step_inc[SizeWidth-1:0];
            end
            else
            begin
                adv_step = '0;
                adv_move = move_t'(move_reg + 1'b1);
                if (move_reg == MOVE_Y_BACK)
                begin
                    adv_size = (size_inc > (SizeWidth+1)'(SIZE_LIMIT)) ?
                               SizeWidth'(1) : size_inc[SizeWidth-1:0];
                end
            end
        end
    end

    always_comb
    begin
        run_next   = run_reg;
        seq_next   = seq_reg;
        size_next  = size_reg;
        move_next  = move_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        left_next  = left_reg;
        hold_next  = hold_reg;
        do_write   = 1'b0;
        case (kind)
            KIND_TICK:
            begin
                if (seq_reg)
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        if (!run_reg)
                        begin
                            seq_next   = 1'b0;
                            size_next  = SizeWidth'(1);
                            move_next  = MOVE_X_FWD;
                            step_next  = '0;
                            phase_next = '0;
                        end
                        else
                        begin
                            size_next  = adv_size;
                            move_next  = adv_move;
                            step_next  = adv_step;
                            phase_next = adv_phase;
                            left_next  = hold_load;
                            do_write   = 1'b1;
                        end
                    end
                end
            end
            KIND_TOGGLE:
            begin
                run_next = !run_reg;
                if (!run_reg && !seq_reg)
                begin
                    seq_next   = 1'b1;
                    size_next  = SizeWidth'(1);
                    move_next  = MOVE_X_FWD;
                    step_next  = '0;
                    phase_next = '0;
                    left_next  = hold_load;
                    do_write   = 1'b1;
                end
            end
            KIND_SPEED:
            begin
                hold_next = {speed_sample, 1'b0};
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    assign wr_phase = phase_next;
    assign wr_move  = move_next;
    assign wr_code  = (wr_move == MOVE_X_BACK || wr_move == MOVE_Y_BACK) ?
                      phase_code(2'd3 - wr_phase) : phase_code(wr_phase);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (do_write)
        begin
            if (wr_move == MOVE_X_FWD || wr_move == MOVE_X_BACK)
            begin
                x_next = wr_code;
            end
            else
            begin
                y_next = wr_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            seq_reg   <= 1'b0;
            size_reg  <= SizeWidth'(1);
            move_reg  <= MOVE_X_FWD;
            step_reg  <= '0;
            phase_reg <= '0;
            left_reg  <= '0;
            hold_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else if (en)
        begin
            run_reg   <= run_next;
            seq_reg   <= seq_next;
            size_reg  <= size_next;
            move_reg  <= move_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
            hold_reg  <= hold_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

    assign status_next.square_size = size_next;
    assign status_next.busy_flag   = seq_next;
    assign status_next.run_flag    = run_next;
    assign status_next.y_coils     = y_next;
    assign status_next.x_coils     = x_next;

`ifndef ASSERT_OFF
    a_hold_live: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg |-> left_reg != '0)
        else $error("Sequence running with an expired hold.");

    a_size_odd: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg[0] == 1'b1)
        else $error("Pattern size is not odd.");

    a_idle_home: assert property (@(posedge clk) disable iff (!rst_n)
        !seq_reg |-> (size_reg == SizeWidth'(1) && move_reg == MOVE_X_FWD &&
                      step_reg == '0 && phase_reg == '0))
        else $error("Idle sequencer is not at the pattern start.");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= size_reg)
        else $error("Step count passed the pattern size.");
`endif

endmodule

// ===== rtl/two_axis_stepper_pattern_sequencer_core.sv =====
// ---------------------------------------------------------------------------
// Two-axis stepper pattern sequencer core
// Steps two stepper motors through a growing square pattern on tick items.
// ---------------------------------------------------------------------------
// Channel  Direction  Payload
// s_axis   in         tuser = kind, tdata = speed_sample
// m_axis   out        tdata = x_coils, y_coils, run_flag, busy_flag, square_size
//
// A result item is offered once its accepted input item has waited in the
// input register and then passed the step unit into the result register.
// One item is accepted per cycle while results are taken.
// Reset clears the sequencer to stopped, idle, size one, coils off.
// A stalled result holds the input register; nothing is dropped.
// ---------------------------------------------------------------------------
module two_axis_stepper_pattern_sequencer_core
    import tasps_pkg::*;
#(
    parameter int SIZE_LIMIT = SizeLimit
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SampleWidth-1:0] s_tdata,   // [7:0] speed_sample
    input  logic [KindWidth-1:0]   s_tuser,   // [1:0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [ResultWidth-1:0] m_tdata    // [3:0] x_coils, [7:4] y_coils,
                                              // [8] run_flag, [9] busy_flag,
                                              // [15:10] square_size
);

    logic                   in_valid_reg;
    logic [KindWidth-1:0]   kind_reg;
    logic [SampleWidth-1:0] sample_reg;
    logic                   out_valid_reg;
    result_t                result_reg;
    result_t                status_next;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            kind_reg   <= s_tuser;
            sample_reg <= s_tdata;
        end
        if (advance)
        begin
            result_reg <= status_next;
        end
    end

    tasps_step_unit #(
        .SIZE_LIMIT (SIZE_LIMIT)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .kind         (kind_reg),
        .speed_sample (sample_reg),
        .status_next  (status_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule
